/* hw/rtl/heightmap_normal_stencil_core_defines.svh */
// assertion helpers shared by the rtl
`ifndef HEIGHTMAP_NORMAL_STENCIL_CORE_DEFINES_SVH
`define HEIGHTMAP_NORMAL_STENCIL_CORE_DEFINES_SVH

// same-cycle implication
`define HNS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hns_pkg.sv */
package hns_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int MAX_GRID    = 1024;
    localparam int ADDR_BITS   = $clog2(MAX_GRID);
    localparam int GRID_BITS   = 11;
    localparam int SCALE_BITS  = 16;
    localparam int CFG_IDX_BITS = 2;

    // magnitude of scale * height difference
    localparam int MAG_BITS  = SCALE_BITS + SAMPLE_BITS;
    localparam int SQ_BITS   = 2 * MAG_BITS + 2;
    localparam int ROOT_BITS = SQ_BITS / 2;
    localparam int DV_BITS   = MAG_BITS + 16;
    localparam int CNT_BITS  = $clog2(DV_BITS + 1);
    localparam int ONE_BITS  = 14;
    localparam int ONE_LOG   = 13;

    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_SIZE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT_SCALE = 2'd1;

    localparam logic [GRID_BITS-1:0]  GRID_MIN    = 11'd3;
    localparam logic [GRID_BITS-1:0]  GRID_MAX    = GRID_BITS'(MAX_GRID);
    localparam logic [GRID_BITS-1:0]  GRID_RESET  = 11'd257;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd410;

    typedef struct packed {
        logic [MAG_BITS-1:0] mag_a;
        logic [MAG_BITS-1:0] mag_b;
        logic                neg_a;
        logic                neg_b;
    } norm_req_t;

    typedef struct packed {
        logic [15:0] nx;
        logic [14:0] ny;
        logic [15:0] nz;
    } norm_res_t;

endpackage

/* hw/rtl/hns_ram.sv */
module hns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/hns_norm_unit.sv */
module hns_norm_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  hns_pkg::norm_req_t req,
    output logic               done,
    output hns_pkg::norm_res_t res
);
    import hns_pkg::*;

    typedef enum logic [2:0] {U_IDLE, U_SQA, U_SQB, U_ROOT, U_DIVLD, U_DIV, U_DONE} ustate_t;
    typedef enum logic [1:0] {SEL_X, SEL_Y, SEL_Z} sel_t;

    ustate_t              state_reg;
    sel_t                 sel_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [MAG_BITS-1:0]  ma_reg, mb_reg;
    logic                 na_reg, nb_reg, half_reg;
    logic [SQ_BITS-1:0]   sq_reg;
    logic [ROOT_BITS:0]   srem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [ROOT_BITS-1:0] drem_reg;
    logic [DV_BITS-1:0]   dvd_reg;
    logic [15:0]          nx_reg, nz_reg;
    logic [14:0]          ny_reg;

    logic                   big;
    logic [2*MAG_BITS-1:0]  prod;
    logic [ONE_BITS-1:0]    one_val;
    logic [ROOT_BITS+2:0]   srem_sh, strial;
    logic                   sge;
    logic [ROOT_BITS:0]     drem_sh;
    logic                   dge;
    logic [DV_BITS-1:0]     q_fin;
    logic [MAG_BITS-1:0]    m_sel;

    function automatic logic [15:0] comp(input logic [DV_BITS-1:0] q, input logic neg);
        logic [16:0] qs;
        qs = (q > DV_BITS'(32768)) ? 17'h10000 : q[16:0];
        if (neg)
        begin
            return (q > DV_BITS'(32767)) ? 16'h7fff : q[15:0];
        end
        return 16'(17'h10000 - qs);
    endfunction

    assign big     = (|(req.mag_a >> 31)) | (|(req.mag_b >> 31));
    assign prod    = (state_reg == U_SQA) ? ma_reg * ma_reg : mb_reg * mb_reg;
    assign one_val = half_reg ? ONE_BITS'(1 << (ONE_LOG - 1)) : ONE_BITS'(1 << ONE_LOG);

    // one restoring square root step
    assign srem_sh = {srem_reg, sq_reg[SQ_BITS-1 -: 2]};
    assign strial  = {1'b0, root_reg, 2'b01};
    assign sge     = srem_sh >= strial;

    // one restoring division step
    assign drem_sh = {drem_reg, dvd_reg[DV_BITS-1]};
    assign dge     = drem_sh >= {1'b0, root_reg};
    assign q_fin   = {dvd_reg[DV_BITS-2:0], dge};

    always_comb
    begin
        case (sel_reg)
            SEL_X:   m_sel = ma_reg;
            SEL_Y:   m_sel = MAG_BITS'(one_val);
            default: m_sel = mb_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            sel_reg   <= SEL_X;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        ma_reg    <= big ? (req.mag_a >> 1) : req.mag_a;
                        mb_reg    <= big ? (req.mag_b >> 1) : req.mag_b;
                        na_reg    <= req.neg_a;
                        nb_reg    <= req.neg_b;
                        half_reg  <= big;
                        state_reg <= U_SQA;
                    end
                end
                U_SQA:
                begin
                    sq_reg    <= SQ_BITS'(prod);
                    state_reg <= U_SQB;
                end
                U_SQB:
                begin
                    sq_reg    <= sq_reg + SQ_BITS'(prod)
                                 + (SQ_BITS'(1) << (2 * (ONE_LOG - (half_reg ? 1 : 0))));
                    srem_reg  <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= U_ROOT;
                end
                U_ROOT:
                begin
                    srem_reg <= sge ? (ROOT_BITS+1)'(srem_sh - strial) : srem_sh[ROOT_BITS:0];
                    root_reg <= {root_reg[ROOT_BITS-2:0], sge};
                    sq_reg   <= sq_reg << 2;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(ROOT_BITS - 1))
                    begin
                        sel_reg   <= SEL_X;
                        state_reg <= U_DIVLD;
                    end
                end
                U_DIVLD:
                begin
                    // round to nearest by adding half the divisor
                    dvd_reg   <= (DV_BITS'(m_sel) << 15) + DV_BITS'(root_reg >> 1);
                    drem_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= U_DIV;
                end
                U_DIV:
                begin
                    drem_reg <= dge ? ROOT_BITS'(drem_sh - {1'b0, root_reg})
                                    : drem_sh[ROOT_BITS-1:0];
                    dvd_reg  <= q_fin;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(DV_BITS - 1))
                    begin
                        case (sel_reg)
                            SEL_X:
                            begin
                                nx_reg    <= comp(q_fin, na_reg);
                                sel_reg   <= SEL_Y;
                                state_reg <= U_DIVLD;
                            end
                            SEL_Y:
                            begin
                                ny_reg    <= (q_fin > DV_BITS'(32767)) ? 15'h7fff : q_fin[14:0];
                                sel_reg   <= SEL_Z;
                                state_reg <= U_DIVLD;
                            end
                            default:
                            begin
                                nz_reg    <= comp(q_fin, nb_reg);
                                state_reg <= U_DONE;
                            end
                        endcase
                    end
                end
                U_DONE:
                begin
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done   = (state_reg == U_DONE);
    assign res.nx = nx_reg;
    assign res.ny = ny_reg;
    assign res.nz = nz_reg;

endmodule

/* hw/rtl/heightmap_normal_stencil_core.sv */
// Central-difference unit normals of a square height grid streamed in raster order, one
// 8-bit height word per input handshake. The last two rows sit in two 1024-entry row rams
// that are read and written back per word. A border word only passes the accept state and
// S_RD0, S_RD1 and S_RD2. A word that completes an interior point goes on through S_MUL,
// S_GO and S_CALC, where the shared normal unit squares both terms, takes 25 steps of a
// bit-serial square root and runs three bit-serial divisions. The normal comes out of an
// output register, so the next word is taken while the previous normal waits; a further
// normal stalls until it is taken. The row rams come out of reset unwritten and need no
// clearing pass. The user writes grid_size and height_scale only while the block is idle;
// the block does not enforce it. grid_size below 3 acts as 3 and above 1024 as 1024.
module heightmap_normal_stencil_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [hns_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [hns_pkg::SCALE_BITS-1:0]       cfg_wdata,
    // height words
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [hns_pkg::SAMPLE_BITS-1:0]      height_sample,
    // normal words
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [15:0]                   normal_x,
    output logic [14:0]                          normal_y,
    output logic signed [15:0]                   normal_z,
    output logic [hns_pkg::ADDR_BITS-1:0]        point_row,
    output logic [hns_pkg::ADDR_BITS-1:0]        point_col,
    output logic                                 last_of_grid
);
    import hns_pkg::*;

    `include "heightmap_normal_stencil_core_defines.svh"

    typedef enum logic [2:0] {S_IDLE, S_RD0, S_RD1, S_RD2, S_MUL, S_GO, S_CALC, S_PUT} state_t;

    state_t                 state_reg;
    logic [GRID_BITS-1:0]   grid_reg;
    logic [SCALE_BITS-1:0]  scale_reg;
    logic [ADDR_BITS-1:0]   row_reg, col_reg;
    logic [SAMPLE_BITS-1:0] prev_reg, sample_reg;
    logic [SAMPLE_BITS-1:0] top_reg, right_reg, left_reg, bottom_reg;
    logic [ADDR_BITS-1:0]   prow_reg, pcol_reg;
    logic                   plast_reg;
    norm_req_t              req_reg;
    logic                   out_valid_reg;
    logic [15:0]            nx_reg, nz_reg;
    logic [14:0]            ny_reg;
    logic [ADDR_BITS-1:0]   orow_reg, ocol_reg;
    logic                   olast_reg;

    // effective grid size and derived limits
    logic [GRID_BITS-1:0]   eff_n, n_m1;
    logic [ADDR_BITS-1:0]   wcol;
    logic                   interior;
    logic                   col_wrap, row_wrap;

    // row ram ports
    logic [ADDR_BITS-1:0]   r1_raddr, r2_raddr;
    logic [SAMPLE_BITS-1:0] r1_rdata, r2_rdata;
    logic                   ram_we;

    // difference magnitudes for the multiply
    logic [SAMPLE_BITS-1:0] diff_a, diff_b;
    logic                   lt_a, lt_b;

    logic                   unit_start, unit_done;
    norm_res_t              unit_res;

    assign eff_n = (grid_reg < GRID_MIN) ? GRID_MIN :
                   (grid_reg > GRID_MAX) ? GRID_MAX : grid_reg;
    assign n_m1  = eff_n - 1'b1;

    // write-back lags one column; column zero commits the end of the row above
    assign wcol     = (col_reg == '0) ? n_m1[ADDR_BITS-1:0] : col_reg - 1'b1;
    assign interior = (row_reg >= ADDR_BITS'(2)) && (col_reg >= ADDR_BITS'(2))
                      && ({1'b0, col_reg} <= n_m1);
    assign col_wrap = ({1'b0, col_reg} >= n_m1);
    assign row_wrap = ({1'b0, row_reg} >= n_m1);

    // top at c-1 then left at c-2 from the older row; right at c then the moving entry
    always_comb
    begin
        case (state_reg)
            S_RD0:
            begin
                r2_raddr = col_reg - 1'b1;
                r1_raddr = col_reg;
            end
            default:
            begin
                r2_raddr = col_reg - ADDR_BITS'(2);
                r1_raddr = wcol;
            end
        endcase
    end

    assign ram_we = (state_reg == S_RD2);

    hns_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_GRID)
    ) u_row1_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wcol),
        .wdata (prev_reg),
        .raddr (r1_raddr),
        .rdata (r1_rdata)
    );

    hns_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_GRID)
    ) u_row2_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wcol),
        .wdata (r1_rdata),
        .raddr (r2_raddr),
        .rdata (r2_rdata)
    );

    assign lt_a   = right_reg < left_reg;
    assign lt_b   = top_reg < bottom_reg;
    assign diff_a = lt_a ? left_reg - right_reg : right_reg - left_reg;
    assign diff_b = lt_b ? bottom_reg - top_reg : top_reg - bottom_reg;

    assign unit_start = (state_reg == S_GO);

    hns_norm_unit u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .req   (req_reg),
        .done  (unit_done),
        .res   (unit_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            grid_reg      <= GRID_RESET;
            scale_reg     <= SCALE_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_SIZE:    grid_reg  <= cfg_wdata[GRID_BITS-1:0];
                    REG_HEIGHT_SCALE: scale_reg <= cfg_wdata;
                    default:          ;
                endcase
            end

            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= height_sample;
                        state_reg  <= S_RD0;
                    end
                end
                S_RD0:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    top_reg   <= r2_rdata;
                    right_reg <= r1_rdata;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    // rams commit this cycle; counters move on
                    left_reg   <= r2_rdata;
                    bottom_reg <= prev_reg;
                    prev_reg   <= sample_reg;
                    prow_reg   <= row_reg - 1'b1;
                    pcol_reg   <= col_reg - 1'b1;
                    plast_reg  <= ({1'b0, row_reg} == n_m1) && ({1'b0, col_reg} == n_m1);
                    if (col_wrap)
                    begin
                        col_reg <= '0;
                        row_reg <= row_wrap ? '0 : row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                    state_reg <= interior ? S_MUL : S_IDLE;
                end
                S_MUL:
                begin
                    req_reg.mag_a <= scale_reg * diff_a;
                    req_reg.mag_b <= scale_reg * diff_b;
                    req_reg.neg_a <= lt_a && (scale_reg != '0);
                    req_reg.neg_b <= lt_b && (scale_reg != '0);
                    state_reg     <= S_GO;
                end
                S_GO:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (unit_done)
                    begin
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        nx_reg        <= unit_res.nx;
                        ny_reg        <= unit_res.ny;
                        nz_reg        <= unit_res.nz;
                        orow_reg      <= prow_reg;
                        ocol_reg      <= pcol_reg;
                        olast_reg     <= plast_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign normal_z     = nz_reg;
    assign point_row    = orow_reg;
    assign point_col    = ocol_reg;
    assign last_of_grid = olast_reg;

    `HNS_ASSERT_IMP(a_done_in_calc, clk, rst_n, unit_done, state_reg == S_CALC, "unit done outside calc")
    `HNS_ASSERT_NEXT(a_accept_reads, clk, rst_n, in_valid && in_ready, state_reg == S_RD0, "accept did not start reads")
    `HNS_ASSERT_NEXT(a_put_holds, clk, rst_n, (state_reg == S_PUT) && out_valid_reg && !out_ready, (state_reg == S_PUT) && out_valid_reg, "normal overwritten while stalled")
    `HNS_ASSERT_IMP(a_border_no_calc, clk, rst_n, (state_reg == S_RD2) && !interior, !unit_start, "border word started the unit")

endmodule
